// ===== rtl/rfv_pkg.sv =====
package rfv_pkg;

    localparam logic       CMD_DATA = 1'b0;
    localparam logic       CMD_END  = 1'b1;

    localparam logic       REG_TYPE_ONE = 1'b0;
    localparam logic       REG_TYPE_TWO = 1'b1;

    localparam logic [7:0] TYPE_ONE_RESET = 8'd1;
    localparam logic [7:0] TYPE_TWO_RESET = 8'd2;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_COUNT,
        PH_PAYLOAD,
        PH_AMOUNT,
        PH_NUMBERS
    } t_phase;

    typedef enum logic [1:0] {
        SCAN_BLANKS,
        SCAN_DIGITS,
        SCAN_STOPPED
    } t_scan;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_byte_req;

    typedef struct packed {
        logic       we;
        logic       index;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/rfv_in_if.sv =====
interface rfv_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== rtl/rfv_out_if.sv =====
interface rfv_out_if;
    logic valid;
    logic ready;
    logic message_valid;

    modport source (output valid, output message_valid, input ready);
    modport sink   (input valid, input message_valid, output ready);
endinterface

// ===== rtl/rfv_in_reg.sv =====
module rfv_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rfv_in_if.sink             i_req,
    input  logic               i_advance,
    output logic               o_valid,
    output rfv_pkg::t_byte_req o_req
);
    import rfv_pkg::*;

    logic      r_valid;
    t_byte_req r_req;
    logic      n_valid;
    logic      take;

    assign i_req.ready = !r_valid || i_advance;
    assign take        = i_req.valid && i_req.ready;
    assign n_valid     = take ? 1'b1 : (i_advance ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.command   <= i_req.command;
            r_req.data_byte <= i_req.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
endmodule

// ===== rtl/rfv_parser.sv =====
module rfv_parser #(
    parameter int ONE_NUMBER_BYTES   = 2,
    parameter int AMOUNT_FIELD_CHARS = 3,
    parameter int MAX_NUMBER_DIGITS  = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfv_pkg::t_cfg_wr   i_cfg,
    input  logic               i_step,
    input  rfv_pkg::t_byte_req i_req,
    output logic               o_result,
    output logic               o_message_valid
);
    import rfv_pkg::*;

    localparam int PW = $clog2(255 * ONE_NUMBER_BYTES + 1);
    localparam int CW = $clog2(AMOUNT_FIELD_CHARS + 1);
    localparam int DW = $clog2(MAX_NUMBER_DIGITS + 1);

    logic [7:0]  r_code_one, r_code_two;
    t_phase      r_phase, n_phase;
    logic        r_failed, n_failed;
    logic [PW-1:0] r_payload_left, n_payload_left;
    logic [CW-1:0] r_chars, n_chars;
    t_scan       r_scan, n_scan;
    logic        r_neg, n_neg;
    logic [31:0] r_amount, n_amount;
    logic [31:0] r_numbers_left, n_numbers_left;
    logic [DW-1:0] r_digits, n_digits;

    logic [7:0]  c;
    logic        c_digit, c_blank, c_nl, c_one, c_two;
    logic [31:0] digit_val;

    assign c         = i_req.data_byte;
    assign c_digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign c_blank   = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign c_nl      = (c == CHAR_NL);
    assign c_one     = (c == r_code_one);
    assign c_two     = (c == r_code_two);
    assign digit_val = 32'(c[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_one <= TYPE_ONE_RESET;
            r_code_two <= TYPE_TWO_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                REG_TYPE_ONE: r_code_one <= i_cfg.data;
                REG_TYPE_TWO: r_code_two <= i_cfg.data;
                default:      r_code_one <= r_code_one;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_failed       = r_failed;
        n_payload_left = r_payload_left;
        n_chars        = r_chars;
        n_scan         = r_scan;
        n_neg          = r_neg;
        n_amount       = r_amount;
        n_numbers_left = r_numbers_left;
        n_digits       = r_digits;
        if (i_step) begin
            if (i_req.command == CMD_END) begin
                n_phase        = PH_TYPE;
                n_failed       = 1'b0;
                n_payload_left = '0;
                n_chars        = '0;
                n_scan         = SCAN_BLANKS;
                n_neg          = 1'b0;
                n_amount       = '0;
                n_numbers_left = '0;
                n_digits       = '0;
            end else if (!r_failed) begin
                case (r_phase)
                    PH_TYPE, PH_NUMBERS: begin
                        if (r_phase == PH_NUMBERS && c_digit
                            && r_digits < DW'(MAX_NUMBER_DIGITS)) begin
                            n_digits = r_digits + DW'(1);
                        end else if (r_phase == PH_NUMBERS && !c_one && !c_two && !c_nl) begin
                            if (c == CHAR_COMMA) begin
                                n_digits       = '0;
                                n_numbers_left = r_numbers_left - 32'd1;
                                if (r_numbers_left == 32'd1) begin
                                    n_phase = PH_TYPE;
                                end
                            end else begin
                                n_failed = 1'b1;
                            end
                        end else begin
                            // type position
                            n_phase = PH_TYPE;
                            if (c_nl) begin
                                n_phase = PH_TYPE;
                            end else if (c_one) begin
                                n_phase = PH_COUNT;
                            end else if (c_two) begin
                                n_phase  = PH_AMOUNT;
                                n_chars  = '0;
                                n_scan   = SCAN_BLANKS;
                                n_neg    = 1'b0;
                                n_amount = '0;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                    end
                    PH_COUNT: begin
                        n_payload_left = PW'(c) * PW'(ONE_NUMBER_BYTES);
                        n_phase = (c == 8'd0) ? PH_TYPE : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        n_payload_left = r_payload_left - PW'(1);
                        if (r_payload_left == PW'(1)) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_AMOUNT: begin
                        case (r_scan)
                            SCAN_BLANKS: begin
                                if (c_blank) begin
                                    n_scan = SCAN_BLANKS;
                                end else if (c == CHAR_PLUS) begin
                                    n_scan = SCAN_DIGITS;
                                end else if (c == CHAR_MINUS) begin
                                    n_neg  = 1'b1;
                                    n_scan = SCAN_DIGITS;
                                end else if (c_digit) begin
                                    n_amount = digit_val;
                                    n_scan   = SCAN_DIGITS;
                                end else begin
                                    n_scan = SCAN_STOPPED;
                                end
                            end
                            SCAN_DIGITS: begin
                                if (c_digit) begin
                                    n_amount = {r_amount[28:0], 3'b000}
                                             + {r_amount[30:0], 1'b0} + digit_val;
                                end else begin
                                    n_scan = SCAN_STOPPED;
                                end
                            end
                            default: n_scan = r_scan;
                        endcase
                        n_chars = r_chars + CW'(1);
                        if (n_chars == CW'(AMOUNT_FIELD_CHARS)) begin
                            n_numbers_left = n_neg ? (32'd0 - n_amount) : n_amount;
                            n_digits       = '0;
                            n_phase        = (n_amount == 32'd0) ? PH_TYPE : PH_NUMBERS;
                        end
                    end
                    default: n_failed = 1'b1;
                endcase
            end
        end
    end

    // result
    always_comb begin
        o_result        = i_step && (i_req.command == CMD_END);
        o_message_valid = !r_failed && (r_phase == PH_TYPE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TYPE;
            r_failed       <= 1'b0;
            r_payload_left <= '0;
            r_chars        <= '0;
            r_scan         <= SCAN_BLANKS;
            r_neg          <= 1'b0;
            r_amount       <= '0;
            r_numbers_left <= '0;
            r_digits       <= '0;
        end else begin
            r_phase        <= n_phase;
            r_failed       <= n_failed;
            r_payload_left <= n_payload_left;
            r_chars        <= n_chars;
            r_scan         <= n_scan;
            r_neg          <= n_neg;
            r_amount       <= n_amount;
            r_numbers_left <= n_numbers_left;
            r_digits       <= n_digits;
        end
    end
endmodule

// ===== rtl/rfv_out_reg.sv =====
module rfv_out_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_message_valid,
    output logic       o_can_load,
    rfv_out_if.source  o_res
);
    logic r_valid, n_valid;
    logic r_message_valid;

    assign o_can_load = !r_valid || o_res.ready;
    assign n_valid    = i_load ? 1'b1 : (o_res.ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_message_valid <= i_message_valid;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.message_valid = r_message_valid;
endmodule

// ===== rtl/record_format_validator.sv =====
// Record format validator. Takes one message byte (or an end-of-message
// request) per cycle on i_byte_req and returns one message_valid result on
// o_result for each end request. Every request passes through an input
// register and then the parser logic into the result register; an end request
// is loaded into the result register as it leaves the input register. Sustained
// rate is one request per cycle; the only stall is an end request that meets
// a full result register which is not being taken. Type codes are written on
// the cfg port (index 0 = format-one code, index 1 = format-two code); the
// user must have them written only while idle, as the block does not enforce it.
module record_format_validator #(
    parameter int ONE_NUMBER_BYTES   = 2,
    parameter int AMOUNT_FIELD_CHARS = 3,
    parameter int MAX_NUMBER_DIGITS  = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfv_in_if.sink     i_byte_req,
    rfv_out_if.source  o_result,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import rfv_pkg::*;

    logic      stage_valid;
    t_byte_req stage_req;
    logic      advance;
    logic      can_load;
    logic      result;
    logic      message_valid;
    t_cfg_wr   cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign advance = stage_valid && ((stage_req.command == CMD_DATA) || can_load);

    rfv_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_byte_req),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_req     (stage_req)
    );

    rfv_parser #(
        .ONE_NUMBER_BYTES   (ONE_NUMBER_BYTES),
        .AMOUNT_FIELD_CHARS (AMOUNT_FIELD_CHARS),
        .MAX_NUMBER_DIGITS  (MAX_NUMBER_DIGITS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_step          (advance),
        .i_req           (stage_req),
        .o_result        (result),
        .o_message_valid (message_valid)
    );

    rfv_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (result),
        .i_message_valid (message_valid),
        .o_can_load      (can_load),
        .o_res           (o_result)
    );
endmodule

// ===== bench/rfv_format_monitor.sv =====
module rfv_format_monitor
    import rfv_pkg::*;
#(
    parameter int ONE_NUMBER_BYTES   = 2,
    parameter int AMOUNT_FIELD_CHARS = 3,
    parameter int MAX_NUMBER_DIGITS  = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfv_in_if          i_req,
    rfv_out_if         i_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_pending,
    output int         o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  code_one;
    logic [7:0]  code_two;
    t_phase      phase;
    logic        failed;
    logic [10:0] payload_left;
    logic [3:0]  amt_chars;
    t_scan       scan;
    logic        amt_neg;
    logic [31:0] amt_val;
    logic [31:0] nums_left;
    logic [3:0]  digits;

    logic verdict_q[$];
    int   mismatches = 0;

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void note_failure(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t monitor: %s", $time, what);
        end
    endfunction

    task automatic clear_message();
        phase        = PH_TYPE;
        failed       = 1'b0;
        payload_left = '0;
        amt_chars    = '0;
        scan         = SCAN_BLANKS;
        amt_neg      = 1'b0;
        amt_val      = '0;
        nums_left    = '0;
        digits       = '0;
    endtask

    // newline in type position is skipped; format one wins when codes match
    task automatic parse_type(input logic [7:0] c);
        if (c != CHAR_NL) begin
            if (c == code_one) begin
                phase = PH_COUNT;
            end else if (c == code_two) begin
                phase     = PH_AMOUNT;
                amt_chars = '0;
                scan      = SCAN_BLANKS;
                amt_neg   = 1'b0;
                amt_val   = '0;
            end else begin
                failed = 1'b1;
            end
        end
    endtask

    task automatic parse_amount_char(input logic [7:0] c);
        if (scan == SCAN_BLANKS) begin
            if (blank_char(c)) begin
            end else if (c == CHAR_PLUS) begin
                scan = SCAN_DIGITS;
            end else if (c == CHAR_MINUS) begin
                amt_neg = 1'b1;
                scan    = SCAN_DIGITS;
            end else if (digit_char(c)) begin
                amt_val = 32'(c - CHAR_ZERO);
                scan    = SCAN_DIGITS;
            end else begin
                scan = SCAN_STOPPED;
            end
        end else if (scan == SCAN_DIGITS) begin
            if (digit_char(c)) begin
                amt_val = amt_val * 32'd10 + 32'(c - CHAR_ZERO);
            end else begin
                scan = SCAN_STOPPED;
            end
        end
        amt_chars = amt_chars + 4'd1;
        if (amt_chars >= AMOUNT_FIELD_CHARS) begin
            nums_left = amt_neg ? 32'd0 - amt_val : amt_val;
            digits    = '0;
            phase     = (nums_left == 32'd0) ? PH_TYPE : PH_NUMBERS;
        end
    endtask

    task automatic parse_number_char(input logic [7:0] c);
        if (digit_char(c) && digits < MAX_NUMBER_DIGITS) begin
            digits = digits + 4'd1;
        end else if (c == code_one || c == code_two || c == CHAR_NL) begin
            phase = PH_TYPE;
            parse_type(c);
        end else if (c == CHAR_COMMA) begin
            digits    = '0;
            nums_left = nums_left - 32'd1;
            if (nums_left == 32'd0) begin
                phase = PH_TYPE;
            end
        end else begin
            failed = 1'b1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        if (!failed) begin
            case (phase)
                PH_TYPE: begin
                    parse_type(c);
                end
                PH_COUNT: begin
                    payload_left = 11'(int'(c) * ONE_NUMBER_BYTES);
                    phase = (payload_left == '0) ? PH_TYPE : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    payload_left = payload_left - 11'd1;
                    if (payload_left == '0) begin
                        phase = PH_TYPE;
                    end
                end
                PH_AMOUNT: begin
                    parse_amount_char(c);
                end
                PH_NUMBERS: begin
                    parse_number_char(c);
                end
                default: begin
                    failed = 1'b1;
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        logic wanted;
        if (!i_rst_n) begin
            code_one = TYPE_ONE_RESET;
            code_two = TYPE_TWO_RESET;
            clear_message();
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TYPE_ONE) begin
                    code_one = i_cfg_data;
                end else if (i_cfg_index == REG_TYPE_TWO) begin
                    code_two = i_cfg_data;
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.command == CMD_END) begin
                    verdict_q.push_back(!failed && phase == PH_TYPE);
                    clear_message();
                end else begin
                    parse_byte(i_req.data_byte);
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (verdict_q.size() == 0) begin
                    note_failure($sformatf("unexpected result, message_valid %0b",
                                           i_res.message_valid));
                end else begin
                    wanted = verdict_q.pop_front();
                    if (i_res.message_valid !== wanted) begin
                        note_failure($sformatf("message_valid expected %0b got %0b",
                                               wanted, i_res.message_valid));
                    end
                end
            end
        end
        o_pending <= verdict_q.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfv_pkg::*;

    localparam int ONE_NUMBER_BYTES   = 2;
    localparam int AMOUNT_FIELD_CHARS = 3;
    localparam int MAX_NUMBER_DIGITS  = 5;
    localparam int STALL_LIMIT        = 400;
    localparam int PHASE_ITEMS        = 130;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    int         pending;
    int         errors;
    int         idle_cycles = 0;
    int         sent;
    bit         idle_en = 1'b1;
    logic [7:0] code_one;
    logic [7:0] code_two;
    logic [7:0] msg_q[$];

    rfv_in_if  byte_req ();
    rfv_out_if result ();

    record_format_validator #(
        .ONE_NUMBER_BYTES   (ONE_NUMBER_BYTES),
        .AMOUNT_FIELD_CHARS (AMOUNT_FIELD_CHARS),
        .MAX_NUMBER_DIGITS  (MAX_NUMBER_DIGITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_req  (byte_req),
        .o_result    (result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rfv_format_monitor #(
        .ONE_NUMBER_BYTES   (ONE_NUMBER_BYTES),
        .AMOUNT_FIELD_CHARS (AMOUNT_FIELD_CHARS),
        .MAX_NUMBER_DIGITS  (MAX_NUMBER_DIGITS)
    ) u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (byte_req),
        .i_res       (result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_req.valid && byte_req.ready) || (result.valid && result.ready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        result.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            result.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (idle_en && $urandom_range(0, 2) == 0) begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    task automatic send_req(input logic cmd, input logic [7:0] value);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            byte_req.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        byte_req.valid     <= 1'b1;
        byte_req.command   <= cmd;
        byte_req.data_byte <= value;
        @(posedge i_clk);
        while (!byte_req.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_message();
        foreach (msg_q[k]) begin
            send_req(CMD_DATA, msg_q[k]);
        end
        send_req(CMD_END, 8'($urandom));
    endtask

    // drain all results; byte requests leave nothing to wait for, so pad past latency
    task automatic settle();
        byte_req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly well-formed records with random content; some noise, corruption, truncation
    task automatic compose_message();
        int         kind;
        int         count;
        int         len;
        logic [7:0] field [AMOUNT_FIELD_CHARS];
        msg_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 4) == 0) begin
                    msg_q.push_back(CHAR_NL);
                end
                if ($urandom_range(0, 1) == 0) begin
                    count = ($urandom_range(0, 40) == 0) ? $urandom_range(4, 255)
                                                         : $urandom_range(0, 3);
                    msg_q.push_back(code_one);
                    msg_q.push_back(8'(count));
                    repeat (count * ONE_NUMBER_BYTES) msg_q.push_back(8'($urandom));
                end else begin
                    count = $urandom_range(0, 4);
                    msg_q.push_back(code_two);
                    foreach (field[k]) begin
                        field[k] = ($urandom_range(0, 1) == 0) ? CHAR_SPACE
                                                               : 8'($urandom_range(9, 13));
                    end
                    case ($urandom_range(0, 5))
                        0: begin
                            field[0] = CHAR_ZERO + 8'(count);
                        end
                        1: begin
                            field[AMOUNT_FIELD_CHARS - 1] = CHAR_ZERO + 8'(count);
                        end
                        2: begin
                            field[0] = CHAR_PLUS;
                            field[1] = CHAR_ZERO + 8'(count);
                        end
                        3: begin
                            // negative amount; -1 wraps to a huge count, -0 gives a count of zero
                            field[0] = CHAR_MINUS;
                            field[1] = ($urandom_range(0, 3) == 0) ? CHAR_ZERO + 8'd1 : CHAR_ZERO;
                            count = $urandom_range(0, 1);
                        end
                        4: begin
                            foreach (field[k]) field[k] = 8'($urandom);
                        end
                        default: begin
                            field[0] = CHAR_ZERO;
                            field[1] = CHAR_ZERO + 8'(count);
                        end
                    endcase
                    foreach (field[k]) msg_q.push_back(field[k]);
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, count) : count;
                    repeat (len) begin
                        repeat (($urandom_range(0, 7) == 0) ? MAX_NUMBER_DIGITS + 1
                                : $urandom_range(0, MAX_NUMBER_DIGITS)) begin
                            msg_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                        end
                        msg_q.push_back(CHAR_COMMA);
                    end
                    if (len < count && $urandom_range(0, 1) == 0) begin
                        msg_q.push_back(CHAR_NL);
                    end
                end
            end
            if (kind == 1 && msg_q.size() != 0) begin
                msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
            end else if (kind == 2) begin
                repeat ($urandom_range(1, 3)) begin
                    if (msg_q.size() != 0) begin
                        void'(msg_q.pop_back());
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= REG_TYPE_ONE;
        i_cfg_data         <= 8'h00;
        byte_req.valid     <= 1'b0;
        byte_req.command   <= CMD_DATA;
        byte_req.data_byte <= 8'h00;
        code_one = TYPE_ONE_RESET;
        code_two = TYPE_TWO_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset codes
        msg_q.delete();
        send_message();
        msg_q = '{CHAR_NL, TYPE_ONE_RESET, 8'h00};
        send_message();
        msg_q = '{TYPE_TWO_RESET, CHAR_MINUS, CHAR_ZERO, CHAR_SPACE};
        send_message();
        msg_q = '{TYPE_TWO_RESET, CHAR_PLUS, CHAR_ZERO + 8'd2, CHAR_COMMA, CHAR_COMMA,
                  CHAR_ZERO + 8'd9, CHAR_NL};
        send_message();
        msg_q = '{8'hFF, 8'h00};
        send_message();
        msg_q = '{TYPE_ONE_RESET, 8'h01, 8'hAA};
        send_message();
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    code_one = 8'h00;
                    code_two = 8'hFF;
                end
                1: begin
                    code_one = 8'hFF;
                    code_two = 8'h00;
                end
                2: begin
                    code_one = 8'h07;
                    code_two = 8'h07;
                end
                3: begin
                    code_one = CHAR_NL;
                    code_two = 8'h03;
                end
                4: begin
                    code_one = CHAR_COMMA;
                    code_two = CHAR_ZERO + 8'd5;
                end
                default: begin
                    code_one = TYPE_ONE_RESET;
                    code_two = TYPE_TWO_RESET;
                end
            endcase
            idle_en = (ph != 2 && ph != 5);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_TYPE_ONE;
            i_cfg_data  <= code_one;
            @(posedge i_clk);
            i_cfg_index <= REG_TYPE_TWO;
            i_cfg_data  <= code_two;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                compose_message();
                send_message();
            end
            settle();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rfv_pkg.sv
rtl/rfv_in_if.sv
rtl/rfv_out_if.sv
rtl/rfv_in_reg.sv
rtl/rfv_parser.sv
rtl/rfv_out_reg.sv
rtl/record_format_validator.sv
bench/rfv_format_monitor.sv
bench/testbench.sv
